>>> rtl/key_set_free_and_max_tracker_macros.svh
// ---------------------------------------------------------------------------
// Key set tracker assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef KEY_SET_FREE_AND_MAX_TRACKER_MACROS_SVH
`define KEY_SET_FREE_AND_MAX_TRACKER_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define KSFMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key set tracker check failed");

// Antecedent implies consequent in the following cycle
`define KSFMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key set tracker check failed");

`endif

>>> rtl/ksfmt_pkg.sv
// ---------------------------------------------------------------------------
// Key set tracker package
// Sizes of the presence bitmap, its word memory and bit-search helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package ksfmt_pkg;

  // Key space and field widths
  localparam int KEY_SPACE = 1024;
  localparam int KEY_W     = 10;
  localparam int FREE_W    = 11;

  // Bitmap is held as words of WORD_W bits
  localparam int WORD_W    = 32;
  localparam int IDX_W     = $clog2(WORD_W);
  localparam int WORDS     = KEY_SPACE / WORD_W;
  localparam int WADDR_W   = $clog2(WORDS);

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_DEL  = 1'b1;

  // Result of a bit search within one word
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } bit_pos_t;

  // Highest set bit, binary halving search
  function automatic bit_pos_t highest_one(logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] upper;
    bit_pos_t          res;
    cur       = v;
    res.idx   = '0;
    res.found = |v;
    for (int l = IDX_W - 1; l >= 0; l--) begin
      upper = cur >> (1 << l);
      if (upper != '0) begin
        res.idx[l] = 1'b1;
        cur = upper;
      end
      cur = cur & ~({WORD_W{1'b1}} << (1 << l));
    end
    return res;
  endfunction

  // Lowest set bit, binary halving search
  function automatic bit_pos_t lowest_one(logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] lower;
    bit_pos_t          res;
    cur       = v;
    res.idx   = '0;
    res.found = |v;
    for (int l = IDX_W - 1; l >= 0; l--) begin
      lower = cur & ~({WORD_W{1'b1}} << (1 << l));
      if (lower == '0) begin
        res.idx[l] = 1'b1;
        cur = cur >> (1 << l);
      end else begin
        cur = lower;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/key_set_free_and_max_tracker.sv
// Each input beat reads its key's bitmap word, writes back any change to it
// and ends in a finish state. A first-free advance or a highest-key rescan in
// between reads one 32-bit bitmap word per cycle from the word memory.
// One beat is in work at a time; a finished result waits in the output register.
// Reset clears the bitmap at once through per-word valid flops: no clearing pass.
// First-free resets to 1 and highest key to 0.
// ---------------------------------------------------------------------------
// Key set free and max tracker
// Presence bitmap in a word memory with running first-free and highest key.
// ---------------------------------------------------------------------------
`default_nettype none

module key_set_free_and_max_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] key, [15:10] zero
  input  wire logic        s_axis_tuser,   // [0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // [0] found, [11:1] first_free,
                                           // [21:12] highest_key, [23:22] zero
);

  `include "key_set_free_and_max_tracker_macros.svh"

  localparam int WW = ksfmt_pkg::WORD_W;
  localparam int IW = ksfmt_pkg::IDX_W;
  localparam int AW = ksfmt_pkg::WADDR_W;
  localparam int KW = ksfmt_pkg::KEY_W;
  localparam int FW = ksfmt_pkg::FREE_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(ksfmt_pkg::WORDS - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UP   = 3'd2;
  localparam logic [2:0] ST_DN   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [KW-1:0] key_q, key_d;
  logic          func_q, func_d;
  logic [FW-1:0] free_q, free_d;
  logic [KW-1:0] top_q, top_d;
  logic          found_q, found_d;
  logic [AW-1:0] scan_w_q, scan_w_d;
  logic          out_valid_q, out_valid_d;
  logic [23:0]   out_data_q, out_data_d;

  // Word memory and its per-word valid flops
  logic [WW-1:0] mem [ksfmt_pkg::WORDS];
  logic [ksfmt_pkg::WORDS-1:0] vld_q;
  logic [WW-1:0] rdata_q;
  logic          rd_vld_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] rd_word;

  // Decode of the held key
  logic [AW-1:0] key_w;
  logic [IW-1:0] key_b;
  logic [WW-1:0] bit_mask;
  logic [WW-1:0] low_fill;
  logic [WW-1:0] mod_add;
  logic [WW-1:0] mod_del;
  logic          key_present;
  logic          key_in_range;
  logic          in_acc;
  logic          out_load;
  ksfmt_pkg::bit_pos_t rd_up_pos;
  ksfmt_pkg::bit_pos_t rd_dn_pos;
  ksfmt_pkg::bit_pos_t scan_up_pos;
  ksfmt_pkg::bit_pos_t scan_dn_pos;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign rd_word      = rd_vld_q ? rdata_q : '0;
  assign key_w        = AW'(key_q >> IW);
  assign key_b        = key_q[IW-1:0];
  assign bit_mask     = WW'(1) << key_b;
  assign low_fill     = {WW{1'b1}} >> (IW'(WW - 1) - key_b);
  assign mod_add      = rd_word | bit_mask;
  assign mod_del      = rd_word & ~bit_mask;
  assign key_present  = |(rd_word & bit_mask);
  assign key_in_range = (32'(key_q) < ksfmt_pkg::KEY_SPACE);

  // Bit searches: in the key's own word and in scanned words
  assign rd_up_pos   = ksfmt_pkg::lowest_one(~(mod_add | low_fill));
  assign rd_dn_pos   = ksfmt_pkg::highest_one(mod_del);
  assign scan_up_pos = ksfmt_pkg::lowest_one(~rd_word);
  assign scan_dn_pos = ksfmt_pkg::highest_one(rd_word);

  // Sequencer: read, modify, write back, then scan words if needed
  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    func_d    = func_q;
    free_d    = free_q;
    top_d     = top_q;
    found_d   = found_q;
    scan_w_d  = scan_w_q;
    rd_en     = 1'b0;
    rd_addr   = key_w;
    mem_we    = 1'b0;
    mem_wdata = mod_add;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          key_d   = s_axis_tdata[KW-1:0];
          func_d  = s_axis_tuser;
          rd_en   = 1'b1;
          rd_addr = AW'(s_axis_tdata[KW-1:0] >> IW);
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_FIN;
        if (!key_in_range) begin
          found_d = 1'b0;
        end else if (func_q == ksfmt_pkg::OP_ADD) begin
          mem_we    = 1'b1;
          mem_wdata = mod_add;
          found_d   = 1'b1;
          if (key_q > top_q) begin
            top_d = key_q;
          end
          if (FW'(key_q) == free_q) begin
            if (rd_up_pos.found) begin
              free_d = FW'({key_w, rd_up_pos.idx});
            end else if (key_w == LAST_WORD) begin
              free_d = FW'(ksfmt_pkg::KEY_SPACE);
            end else begin
              rd_en    = 1'b1;
              rd_addr  = key_w + 1'b1;
              scan_w_d = key_w + 1'b1;
              state_d  = ST_UP;
            end
          end
        end else if (!key_present) begin
          found_d = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mod_del;
          found_d   = 1'b1;
          if (FW'(key_q) < free_q) begin
            free_d = FW'(key_q);
          end
          // Highest key gone: nothing above it is present, search downwards
          if (key_q == top_q) begin
            if (rd_dn_pos.found) begin
              top_d = KW'({key_w, rd_dn_pos.idx});
            end else if (key_w == '0) begin
              top_d = '0;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = key_w - 1'b1;
              scan_w_d = key_w - 1'b1;
              state_d  = ST_DN;
            end
          end
        end
      end
      ST_UP: begin
        if (scan_up_pos.found) begin
          free_d  = FW'({scan_w_q, scan_up_pos.idx});
          state_d = ST_FIN;
        end else if (scan_w_q == LAST_WORD) begin
          free_d  = FW'(ksfmt_pkg::KEY_SPACE);
          state_d = ST_FIN;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = scan_w_q + 1'b1;
          scan_w_d = scan_w_q + 1'b1;
        end
      end
      ST_DN: begin
        if (scan_dn_pos.found) begin
          top_d   = KW'({scan_w_q, scan_dn_pos.idx});
          state_d = ST_FIN;
        end else if (scan_w_q == '0) begin
          top_d   = '0;
          state_d = ST_FIN;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = scan_w_q - 1'b1;
          scan_w_d = scan_w_q - 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {2'b00, top_q, free_q, found_q};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_q      <= FW'(1);
      top_q       <= '0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        vld_q[key_w] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    func_q     <= func_d;
    found_q    <= found_d;
    scan_w_q   <= scan_w_d;
    out_data_q <= out_data_d;
  end

  // Bitmap word memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[key_w] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Checks
  `KSFMT_ASSERT_SAME(a_free_bounded, 1'b1, free_q <= FW'(ksfmt_pkg::KEY_SPACE))
  `KSFMT_ASSERT_NEXT(a_acc_reads, in_acc, state_q == ST_RD)
  `KSFMT_ASSERT_SAME(a_result_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN)
  `KSFMT_ASSERT_NEXT(a_up_scan_steps, state_q == ST_UP && state_d == ST_UP,
                     scan_w_q == $past(scan_w_q) + 1'b1)

endmodule

`default_nettype wire

>>> sim/key_set_free_and_max_tracker_tb.sv
// ---------------------------------------------------------------------------
// Key set free and max tracker testbench
// Drives add and delete beats into the tracker and checks every result beat
// against a cycle-free prediction of the presence map, first-free key and
// highest key. A directed opening covers the corner cases. A shuffled fill of
// the whole key space then saturates first-free, and random churn in narrow
// key windows follows. Source and sink idle at random in several phases, and
// the sink holds off once for a long stretch.
// ---------------------------------------------------------------------------
`default_nettype none

module key_set_free_and_max_tracker_tb;

  // Sizes taken from the shared package
  localparam int KEY_SPACE = ksfmt_pkg::KEY_SPACE;
  localparam int KEY_W     = ksfmt_pkg::KEY_W;
  localparam int FREE_W    = ksfmt_pkg::FREE_W;

  // Idle behaviour attached to each queued beat
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic             func;
    logic [KEY_W-1:0] key;
    idle_mode_e       mode;
  } key_op_t;

  // Packed to match m_axis_tdata[21:0]
  typedef struct packed {
    logic [KEY_W-1:0]  highest_key;
    logic [FREE_W-1:0] first_free;
    logic              found;
  } tracker_result_t;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [9:0] key, [15:10] zero
  logic        s_axis_tuser  = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;         // [0] found, [11:1] first_free,
                                     // [21:12] highest_key, [23:22] zero

  // Predicted tracker state
  logic [KEY_SPACE-1:0] key_present = '0;
  logic [FREE_W-1:0]    next_free   = FREE_W'(1);
  logic [KEY_W-1:0]     max_key     = '0;

  key_op_t         pending_ops[$];
  tracker_result_t expected_results[$];
  key_op_t         next_op;
  idle_mode_e      phase_mode = IDLE_NONE;
  int              in_beats   = 0;
  int              issued     = 0;
  int              total_ops  = 0;
  int              errors     = 0;
  int              quiet_cycles = 0;
  int              hold_left  = 0;
  bit              hold_done  = 1'b0;

  key_set_free_and_max_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Apply one add or delete to the predicted state, return the expected beat
  function automatic tracker_result_t predict_key_op(logic func, logic [KEY_W-1:0] key);
    tracker_result_t r;
    int              f;
    r.found = 1'b1;
    if (func == ksfmt_pkg::OP_ADD) begin
      key_present[key] = 1'b1;
      if (key == next_free) begin
        f = next_free + 1;
        while (f < KEY_SPACE && key_present[KEY_W'(f)]) f++;
        next_free = FREE_W'(f);
      end
      if (key > max_key) max_key = key;
    end else if (!key_present[key]) begin
      r.found = 1'b0;
    end else begin
      key_present[key] = 1'b0;
      if (key < next_free) next_free = FREE_W'(key);
      if (key == max_key) begin
        if (key > 0 && key_present[key - 1'b1]) begin
          max_key = key - 1'b1;
        end else begin
          // full rescan, zero when the map is empty
          max_key = '0;
          for (int k = 0; k < KEY_SPACE; k++) if (key_present[KEY_W'(k)]) max_key = KEY_W'(k);
        end
      end
    end
    r.first_free  = next_free;
    r.highest_key = max_key;
    return r;
  endfunction

  function automatic bit stall_roll(idle_mode_e m, bit source_side);
    int pct;
    pct = 0;
    if (m == IDLE_BOTH) pct = 13;
    else if (source_side && m == IDLE_SRC) pct = 58;
    else if (!source_side && m == IDLE_SINK) pct = 58;
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic queue_op(logic func, int key, idle_mode_e mode);
    key_op_t op;
    op.func = func;
    op.key  = KEY_W'(key);
    op.mode = mode;
    pending_ops.push_back(op);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Source side: present the next queued beat once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_beats == issued) begin
      if (pending_ops.size() != 0 && !stall_roll(pending_ops[0].mode, 1'b1)) begin
        next_op = pending_ops.pop_front();
        s_axis_tdata  <= {{(16-KEY_W){1'b0}}, next_op.key};
        s_axis_tuser  <= next_op.func;
        s_axis_tvalid <= 1'b1;
        issued        <= issued + 1;
        phase_mode    <= next_op.mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random stalls, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && in_beats >= 40) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= !stall_roll(phase_mode, 1'b0);
    end
  end

  // Predict on input beats, compare on output beats, watch for a hang
  always @(posedge clk_i) begin : beat_check
    tracker_result_t want;
    tracker_result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[21:0];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("found", int'(want.found), int'(got.found));
          check_field("first_free", int'(want.first_free), int'(got.first_free));
          check_field("highest_key", int'(want.highest_key), int'(got.highest_key));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_key_op(s_axis_tuser, s_axis_tdata[KEY_W-1:0]));
        in_beats <= in_beats + 1;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int         fill_keys[KEY_SPACE];
    int         j;
    int         tmp;
    int         base;
    int         key;
    idle_mode_e mode;

    // Directed: empty map, key zero, repeats, both highest-key delete paths
    queue_op(ksfmt_pkg::OP_DEL, 5, IDLE_NONE);     // delete on an empty map
    queue_op(ksfmt_pkg::OP_ADD, 0, IDLE_NONE);     // key zero, first-free stays at one
    queue_op(ksfmt_pkg::OP_DEL, 0, IDLE_NONE);     // zero as highest: rescan to empty
    queue_op(ksfmt_pkg::OP_ADD, 0, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_ADD, 1, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_ADD, 2, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_ADD, 1, IDLE_NONE);     // add of a present key
    queue_op(ksfmt_pkg::OP_ADD, 1023, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_ADD, 1022, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 1023, IDLE_NONE);  // key-1 present
    queue_op(ksfmt_pkg::OP_DEL, 1022, IDLE_NONE);  // key-1 absent: rescan
    queue_op(ksfmt_pkg::OP_DEL, 1, IDLE_NONE);     // first-free drops
    queue_op(ksfmt_pkg::OP_ADD, 1, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_ADD, 4, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_ADD, 3, IDLE_NONE);     // first-free skips over 4
    queue_op(ksfmt_pkg::OP_DEL, 4, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 0, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 0, IDLE_NONE);     // now absent
    queue_op(ksfmt_pkg::OP_ADD, 682, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_ADD, 341, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 682, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 341, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 3, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 2, IDLE_NONE);
    queue_op(ksfmt_pkg::OP_DEL, 1, IDLE_NONE);     // back to empty

    // Fill the whole key space in shuffled order so first-free saturates
    for (int i = 0; i < KEY_SPACE; i++) fill_keys[i] = i;
    for (int i = KEY_SPACE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_keys[i];
      fill_keys[i] = fill_keys[j];
      fill_keys[j] = tmp;
    end
    mode = IDLE_NONE;
    for (int i = 0; i < KEY_SPACE; i++) begin
      if (i % 64 == 0) mode = idle_mode_e'($urandom_range(0, 3));
      queue_op(ksfmt_pkg::OP_ADD, fill_keys[i], mode);
    end

    // Churn, mostly in a 16-key window that moves every 32 beats
    base = 0;
    for (int i = 0; i < 700; i++) begin
      if (i % 64 == 0) mode = idle_mode_e'($urandom_range(0, 3));
      if (i % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       base = 0;
          1:       base = KEY_SPACE - 16;
          default: base = $urandom_range(0, KEY_SPACE - 16);
        endcase
      end
      if ($urandom_range(0, 99) < 75) key = base + $urandom_range(0, 15);
      else key = $urandom_range(0, KEY_SPACE - 1);
      queue_op($urandom_range(0, 1) ? ksfmt_pkg::OP_DEL : ksfmt_pkg::OP_ADD, key, mode);
    end
    total_ops = pending_ops.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(in_beats == total_ops && expected_results.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/ksfmt_pkg.sv
rtl/key_set_free_and_max_tracker.sv
sim/key_set_free_and_max_tracker_tb.sv
